### src/status_led_pattern_engine_unit_macros.svh
// Assertion helpers shared by the pattern engine modules.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef STATUS_LED_PATTERN_ENGINE_UNIT_MACROS_SVH
`define STATUS_LED_PATTERN_ENGINE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLPE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold at every clock edge out of reset.
`define SLPE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

### src/slpe_pkg.sv
package slpe_pkg;

    // Sine table size and the index width that follows from it
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);

    // Shared divider: 38-bit dividend (now_ms times a 6-bit frequency), 16-bit divisor,
    // two quotient bits per cycle
    localparam int DIV_W     = 38;
    localparam int DIVISOR_W = 16;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic [DIV_W-1:0]     div_word_t;
    typedef logic [DIVISOR_W-1:0] div_den_t;

    // Display modes
    localparam logic [3:0] MODE_OFFLINE    = 4'd0;
    localparam logic [3:0] MODE_IDLE       = 4'd1;
    localparam logic [3:0] MODE_TALK       = 4'd2;
    localparam logic [3:0] MODE_INCOMING   = 4'd3;
    localparam logic [3:0] MODE_LIVE       = 4'd4;
    localparam logic [3:0] MODE_WARNING    = 4'd5;
    localparam logic [3:0] MODE_RECORDING  = 4'd6;
    localparam logic [3:0] MODE_REMIND     = 4'd7;
    localparam logic [3:0] MODE_SOS_ARMING = 4'd8;
    localparam logic [3:0] MODE_SOS_ACTIVE = 4'd9;
    localparam logic [3:0] MODE_LAST       = MODE_SOS_ACTIVE;

    // Item operations
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SET    = 1'b1;

    // Configuration register indexes and reset values
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] CFG_TALK_FADE    = 2'd0;
    localparam logic [1:0] CFG_INCOMING     = 2'd1;
    localparam logic [1:0] CFG_REMIND       = 2'd2;
    localparam logic [1:0] CFG_SOS_HALF     = 2'd3;

    localparam logic [15:0] TALK_FADE_RST   = 16'd2000;
    localparam logic [15:0] INCOMING_RST    = 16'd4500;
    localparam logic [15:0] REMIND_RST      = 16'd6000;
    localparam logic [15:0] SOS_HALF_RST    = 16'd180;

    // Phase period in tenths of a hertz times milliseconds
    localparam div_den_t   PHASE_MOD        = 16'd10000;
    localparam logic [7:0] FADE_PEAK        = 8'd240;

    // Colour factors in Q0.8
    localparam logic [7:0] FAC_IDLE_G       = 8'd236;
    localparam logic [7:0] FAC_IDLE_B       = 8'd141;
    localparam logic [7:0] FAC_WARN_G       = 8'd166;
    localparam logic [7:0] FAC_REMIND_G     = 8'd210;
    // x / 3 as (x * 171) >> 9, exact for 8-bit x
    localparam logic [7:0] DIV3_MUL         = 8'd171;

    // Effect kinds
    localparam logic [1:0] KIND_PULSE       = 2'd0;
    localparam logic [1:0] KIND_FADE        = 2'd1;
    localparam logic [1:0] KIND_BLINK       = 2'd2;

    typedef struct packed {
        logic       op;
        logic [3:0] mode;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] shown_mode;
    } result_t;

    typedef struct packed {
        logic [5:0] f10;
        logic [7:0] lo;
        logic [7:0] hi;
    } pulse_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic apply_set;
        logic calc_t;
        logic to_idle;
        logic div_start;
        logic div_index;
        logic rom_read;
        logic mul_pulse;
        logic sum_pulse;
        logic x_from_div;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       op_set;
        logic       timed_out;
        logic [1:0] kind;
        logic       div_busy;
        logic       out_free;
    } dp_status_t;

    // Pulse frequency (0.1 Hz), minimum and maximum for each pulsing mode
    function automatic pulse_t pulse_params(input logic [3:0] mode);
        pulse_t p;
        unique case (mode)
            MODE_OFFLINE:    p = '{f10: 6'd3,  lo: 8'd5,   hi: 8'd30};
            MODE_IDLE:       p = '{f10: 6'd11, lo: 8'd55,  hi: 8'd190};
            MODE_INCOMING:   p = '{f10: 6'd10, lo: 8'd40,  hi: 8'd220};
            MODE_LIVE:       p = '{f10: 6'd11, lo: 8'd70,  hi: 8'd230};
            MODE_WARNING:    p = '{f10: 6'd40, lo: 8'd100, hi: 8'd240};
            MODE_RECORDING:  p = '{f10: 6'd10, lo: 8'd55,  hi: 8'd220};
            MODE_REMIND:     p = '{f10: 6'd15, lo: 8'd70,  hi: 8'd210};
            MODE_SOS_ARMING: p = '{f10: 6'd20, lo: 8'd90,  hi: 8'd255};
            default:         p = '0;
        endcase
        return p;
    endfunction

    // Sine table generation in Q30, folded to the first quadrant
    localparam logic [63:0] Q30_ONE     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 5;
    localparam logic [7:0]  TAYLOR_DIV [TAYLOR_TERMS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

    typedef logic [7:0] sine_rom_t [SINE_TABLE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t   rom;
        logic [63:0] turn;
        logic [63:0] u;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] v;
        logic [1:0]  quad;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            turn = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
            quad = turn[31:30];
            u    = turn & (Q30_ONE - 64'd1);
            a    = quad[0] ? (Q30_ONE - u) : u;
            x    = (a * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            for (int k = 0; k < TAYLOR_TERMS; k++) begin
                d    = ((x2 * term) >> 30) / 64'(TAYLOR_DIV[k]);
                term = (d >= Q30_ONE) ? 64'd0 : (Q30_ONE - d);
            end
            s = (x * term) >> 30;
            if (s > Q30_ONE)
            begin
                s = Q30_ONE;
            end
            v = quad[1] ? (Q30_ONE - s) : (Q30_ONE + s);
            v = v >> 1;
            v = (v + 64'd2097152) >> 22;
            rom[i] = (v > 64'd255) ? 8'hFF : v[7:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### src/status_led_pattern_engine_unit.sv
// Status LED pattern engine. A set beat (op = 1) stores a new mode, 0 to 9, together with
// its now_ms as the mode start time, and gives no result; a set naming mode 10 to 15 is
// dropped. An update beat (op = 0) gives one colour for the mode in force, or, when the
// wants-to-talk, audio-incoming or remind-later mode has run its length, switches to idle
// and gives no result. One item is in work at a time and item_stall is high while it is:
// a set is decoded and applied, a timeout is checked and sends the mode to idle, a fade or
// blink update makes one pass through the shared divider, and a pulse update makes two
// (phase modulo 10000, then the sine index) at two quotient bits per cycle, plus the table
// read, a multiply and an add. The result sits in an output register, so a new item is taken
// while it waits; a result that is still held when the next one is ready stalls the engine in
// its last step. Configuration writes are to be made only while the engine is idle.
module status_led_pattern_engine_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  slpe_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output slpe_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [slpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data
);

    slpe_pkg::ctrl_cmd_t  cmd;
    slpe_pkg::dp_status_t sts;

    slpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    slpe_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### src/slpe_div.sv
`include "status_led_pattern_engine_unit_macros.svh"

module slpe_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  slpe_pkg::div_word_t  dividend,
    input  slpe_pkg::div_den_t   divisor,
    output logic                 busy,
    output slpe_pkg::div_word_t  quotient,
    output slpe_pkg::div_den_t   remainder
);

    slpe_pkg::div_word_t              quo_reg;
    slpe_pkg::div_word_t              quo_next;
    slpe_pkg::div_den_t               rem_reg;
    slpe_pkg::div_den_t               rem_next;
    slpe_pkg::div_den_t               dsor_reg;
    logic [slpe_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             busy_reg;
    logic [slpe_pkg::DIVISOR_W:0]     trial;

    // Two restoring steps per cycle; quotient bits shift in behind the dividend
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < 2; k++) begin
            trial    = {rem_next, quo_next[slpe_pkg::DIV_W-1]};
            quo_next = {quo_next[slpe_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dsor_reg})
            begin
                trial       = trial - {1'b0, dsor_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[slpe_pkg::DIVISOR_W-1:0];
        end
    end

    // Step counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= slpe_pkg::DIV_CNT_W'(slpe_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Load operands, then advance one digit pair per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `SLPE_ASSERT_IMP(a_div_no_restart, start, !busy_reg, "divider restarted while busy")
    `SLPE_ASSERT_IMP(a_div_nonzero, busy_reg, dsor_reg != '0, "divider running on zero divisor")

endmodule

### src/slpe_dpath.sv
`include "status_led_pattern_engine_unit_macros.svh"

module slpe_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  slpe_pkg::ctrl_cmd_t              cmd,
    output slpe_pkg::dp_status_t             sts,
    input  slpe_pkg::item_t                  item,
    input  logic                             cfg_we,
    input  logic [slpe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data,
    output logic                             result_valid,
    input  logic                             result_stall,
    output slpe_pkg::result_t                result
);

    // Configuration
    logic [15:0] fade_reg;
    logic [15:0] incoming_reg;
    logic [15:0] remind_reg;
    logic [15:0] sos_reg;

    // Mode state
    logic [3:0]  mode_reg;
    logic [3:0]  mode_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;

    // Captured item and working registers
    logic        op_reg;
    logic [3:0]  new_mode_reg;
    logic [31:0] now_reg;
    logic [31:0] t_reg;
    logic [7:0]  rom_val_reg;
    logic [15:0] prod_reg;
    logic [7:0]  x_reg;

    // Output register
    slpe_pkg::result_t result_reg;
    slpe_pkg::result_t result_next;
    logic              result_valid_reg;
    logic              result_valid_next;

    slpe_pkg::pulse_t    pp;
    logic [1:0]          kind;
    logic                has_limit;
    logic [15:0]         limit;
    logic [15:0]         fade_left;
    logic [15:0]         sos_half;
    slpe_pkg::div_word_t div_dividend;
    slpe_pkg::div_den_t  div_divisor;
    logic                div_busy;
    slpe_pkg::div_word_t div_quo;
    slpe_pkg::div_den_t  div_rem;
    logic [7:0]          g_fac;
    logic [7:0]          b_fac;
    logic [15:0]         mul_g;
    logic [15:0]         mul_b;
    logic [7:0]          div3;
    logic                blink_on;
    logic                out_free;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_reg     <= slpe_pkg::TALK_FADE_RST;
            incoming_reg <= slpe_pkg::INCOMING_RST;
            remind_reg   <= slpe_pkg::REMIND_RST;
            sos_reg      <= slpe_pkg::SOS_HALF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                slpe_pkg::CFG_TALK_FADE: fade_reg     <= cfg_data;
                slpe_pkg::CFG_INCOMING:  incoming_reg <= cfg_data;
                slpe_pkg::CFG_REMIND:    remind_reg   <= cfg_data;
                slpe_pkg::CFG_SOS_HALF:  sos_reg      <= cfg_data;
            endcase
        end
    end

    // Mode decode: effect kind, pulse shape and timeout length
    always_comb
    begin
        pp        = slpe_pkg::pulse_params(mode_reg);
        kind      = slpe_pkg::KIND_PULSE;
        has_limit = 1'b0;
        limit     = fade_reg;
        if (mode_reg == slpe_pkg::MODE_TALK)
        begin
            kind      = slpe_pkg::KIND_FADE;
            has_limit = 1'b1;
        end
        else if (mode_reg >= slpe_pkg::MODE_SOS_ACTIVE)
        begin
            kind = slpe_pkg::KIND_BLINK;
        end
        else if (mode_reg == slpe_pkg::MODE_INCOMING)
        begin
            has_limit = 1'b1;
            limit     = incoming_reg;
        end
        else if (mode_reg == slpe_pkg::MODE_REMIND)
        begin
            has_limit = 1'b1;
            limit     = remind_reg;
        end
    end

    // Mode and start time: set, timeout back to idle
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        if (cmd.apply_set && (new_mode_reg <= slpe_pkg::MODE_LAST))
        begin
            mode_next  = new_mode_reg;
            start_next = now_reg;
        end
        else if (cmd.to_idle)
        begin
            mode_next  = slpe_pkg::MODE_IDLE;
            start_next = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= slpe_pkg::MODE_OFFLINE;
            start_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
        end
    end

    // Divider operands: phase, sine index, fade level or blink count
    assign fade_left = fade_reg - t_reg[15:0];
    assign sos_half  = (sos_reg == '0) ? 16'd1 : sos_reg;

    always_comb
    begin
        if (cmd.div_index)
        begin
            div_dividend = slpe_pkg::div_word_t'(div_rem)
                         * slpe_pkg::div_word_t'(slpe_pkg::SINE_TABLE_DEPTH);
            div_divisor  = slpe_pkg::PHASE_MOD;
        end
        else
        begin
            unique case (kind)
                slpe_pkg::KIND_FADE:
                begin
                    div_dividend = slpe_pkg::div_word_t'(fade_left)
                                 * slpe_pkg::div_word_t'(slpe_pkg::FADE_PEAK);
                    div_divisor  = fade_reg;
                end
                slpe_pkg::KIND_BLINK:
                begin
                    div_dividend = slpe_pkg::div_word_t'(now_reg);
                    div_divisor  = sos_half;
                end
                default:
                begin
                    div_dividend = slpe_pkg::div_word_t'(now_reg)
                                 * slpe_pkg::div_word_t'(pp.f10);
                    div_divisor  = slpe_pkg::PHASE_MOD;
                end
            endcase
        end
    end

    slpe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Item capture, elapsed time, sine lookup and pulse arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= item.op;
            new_mode_reg <= item.mode;
            now_reg      <= item.now_ms;
        end
        if (cmd.calc_t)
        begin
            t_reg <= now_reg - start_reg;
        end
        if (cmd.rom_read)
        begin
            rom_val_reg <= slpe_pkg::SINE_ROM[div_quo[slpe_pkg::IDX_W-1:0]];
        end
        if (cmd.mul_pulse)
        begin
            prod_reg <= rom_val_reg * (pp.hi - pp.lo);
        end
        if (cmd.sum_pulse)
        begin
            x_reg <= pp.lo + prod_reg[15:8];
        end
        else if (cmd.x_from_div)
        begin
            x_reg <= div_quo[7:0];
        end
    end

    // Colour mapping per mode
    always_comb
    begin
        g_fac = '0;
        b_fac = '0;
        unique case (mode_reg)
            slpe_pkg::MODE_OFFLINE:
            begin
                g_fac = slpe_pkg::DIV3_MUL;
            end
            slpe_pkg::MODE_IDLE, slpe_pkg::MODE_TALK:
            begin
                g_fac = slpe_pkg::FAC_IDLE_G;
                b_fac = slpe_pkg::FAC_IDLE_B;
            end
            slpe_pkg::MODE_WARNING: g_fac = slpe_pkg::FAC_WARN_G;
            slpe_pkg::MODE_REMIND:  g_fac = slpe_pkg::FAC_REMIND_G;
            default:                g_fac = '0;
        endcase
    end

    assign mul_g    = x_reg * g_fac;
    assign mul_b    = x_reg * b_fac;
    assign div3     = {1'b0, mul_g[15:9]};
    assign blink_on = !div_quo[0];

    always_comb
    begin
        result_next            = result_reg;
        result_next.shown_mode = mode_reg;
        unique case (mode_reg)
            slpe_pkg::MODE_OFFLINE:
            begin
                result_next.red   = div3;
                result_next.green = div3;
                result_next.blue  = div3;
            end
            slpe_pkg::MODE_IDLE, slpe_pkg::MODE_TALK:
            begin
                result_next.red   = x_reg;
                result_next.green = mul_g[15:8];
                result_next.blue  = mul_b[15:8];
            end
            slpe_pkg::MODE_INCOMING:
            begin
                result_next.red   = 8'd25;
                result_next.green = 8'd80;
                result_next.blue  = x_reg;
            end
            slpe_pkg::MODE_LIVE:
            begin
                result_next.red   = 8'd10;
                result_next.green = x_reg;
                result_next.blue  = 8'd45;
            end
            slpe_pkg::MODE_WARNING, slpe_pkg::MODE_REMIND:
            begin
                result_next.red   = x_reg;
                result_next.green = mul_g[15:8];
                result_next.blue  = 8'd0;
            end
            slpe_pkg::MODE_RECORDING:
            begin
                result_next.red   = 8'd20;
                result_next.green = 8'd65;
                result_next.blue  = x_reg;
            end
            slpe_pkg::MODE_SOS_ARMING:
            begin
                result_next.red   = x_reg;
                result_next.green = 8'd5;
                result_next.blue  = 8'd5;
            end
            default:
            begin
                result_next.red   = blink_on ? 8'd255 : 8'd20;
                result_next.green = blink_on ? 8'd5 : 8'd0;
                result_next.blue  = blink_on ? 8'd5 : 8'd0;
            end
        endcase
    end

    // Output register: load a new beat, drop the old one once taken
    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Status back to the controller
    always_comb
    begin
        sts.op_set    = (op_reg == slpe_pkg::OP_SET);
        sts.timed_out = has_limit && ((t_reg[31:16] != '0) || (t_reg[15:0] >= limit));
        sts.kind      = kind;
        sts.div_busy  = div_busy;
        sts.out_free  = out_free;
    end

    `SLPE_ASSERT_ALWAYS(a_mode_legal, mode_reg <= slpe_pkg::MODE_LAST, "mode register out of range")

endmodule

### src/slpe_ctrl.sv
`include "status_led_pattern_engine_unit_macros.svh"

module slpe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  slpe_pkg::dp_status_t sts,
    output slpe_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DIV_A  = 3'd3;
    localparam logic [2:0] ST_DIV_B  = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_SUM    = 3'd6;
    localparam logic [2:0] ST_COLOR  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequence one item through the datapath
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.op_set)
                begin
                    cmd.apply_set = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.calc_t = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.timed_out)
                begin
                    cmd.to_idle = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.kind == slpe_pkg::KIND_PULSE)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_index = 1'b1;
                        state_next    = ST_DIV_B;
                    end
                    else
                    begin
                        cmd.x_from_div = 1'b1;
                        state_next     = ST_COLOR;
                    end
                end
            end
            ST_DIV_B:
            begin
                if (!sts.div_busy)
                begin
                    cmd.rom_read = 1'b1;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_pulse = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_pulse = 1'b1;
                state_next    = ST_COLOR;
            end
            ST_COLOR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);

    `SLPE_ASSERT_IMP(a_no_overwrite, cmd.out_load, sts.out_free, "result overwritten before taken")
    `SLPE_ASSERT_IMP(a_rom_after_div, cmd.rom_read, !sts.div_busy, "sine lookup before index ready")

endmodule

### bench/status_led_pattern_engine_unit_tb.sv
module status_led_pattern_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import slpe_pkg::*;

    localparam logic [63:0] Q_ONE = 64'd1 << 30;
    localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};

    // Predicts the color of each update beat and checks the colors that come out
    class color_checker;
        logic [7:0]  wave_lut [SINE_TABLE_DEPTH];
        logic [3:0]  mode_now;
        logic [31:0] mode_since;
        logic [15:0] fade_len;
        logic [15:0] incoming_len;
        logic [15:0] remind_len;
        logic [15:0] sos_half;
        result_t     pending_colors [$];
        int unsigned errors;

        function new();
            logic [63:0] turn;
            logic [63:0] frac;
            logic [63:0] ang;
            logic [63:0] ang_sq;
            logic [63:0] series;
            logic [63:0] d;
            logic [63:0] s;
            logic [63:0] lvl;
            logic [1:0]  quad;
            // Build (sin+1)/2 in Q0.8 from a first-quadrant Horner series in Q30
            for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            begin
                turn   = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
                quad   = turn[31:30];
                frac   = {34'd0, turn[29:0]};
                ang    = quad[0] ? (Q_ONE - frac) : frac;
                ang    = (ang * 64'd1686629713) >> 30;
                ang_sq = (ang * ang) >> 30;
                series = Q_ONE;
                for (int k = 0; k < 5; k++)
                begin
                    d      = ((ang_sq * series) >> 30) / 64'(HORNER_DIV[k]);
                    series = (d >= Q_ONE) ? 64'd0 : (Q_ONE - d);
                end
                s = (ang * series) >> 30;
                if (s > Q_ONE)
                begin
                    s = Q_ONE;
                end
                lvl = quad[1] ? (Q_ONE - s) : (Q_ONE + s);
                lvl = ((lvl >> 1) + (64'd1 << 21)) >> 22;
                wave_lut[i] = (lvl > 64'd255) ? 8'd255 : lvl[7:0];
            end
            mode_now     = MODE_OFFLINE;
            mode_since   = '0;
            fade_len     = 16'd2000;
            incoming_len = 16'd4500;
            remind_len   = 16'd6000;
            sos_half     = 16'd180;
            errors       = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_TALK_FADE: fade_len     = val;
                CFG_INCOMING:  incoming_len = val;
                CFG_REMIND:    remind_len   = val;
                default:       sos_half     = val;
            endcase
        endfunction

        // Sine pulse between lo and hi at f10 tenths of a hertz
        function logic [7:0] pulse_level(logic [31:0] t_ms, int unsigned f10,
                                         int unsigned lo, int unsigned hi);
            logic [63:0] ph;
            int unsigned idx;
            int unsigned lvl;
            ph  = (64'(t_ms) * 64'(f10)) % 64'd10000;
            idx = int'((ph * 64'(SINE_TABLE_DEPTH)) / 64'd10000);
            lvl = wave_lut[idx];
            return 8'(lo + ((lvl * (hi - lo)) >> 8));
        endfunction

        function logic [7:0] dim(logic [7:0] b, int unsigned f);
            return 8'((32'(b) * f) >> 8);
        endfunction

        function void fall_to_idle(logic [31:0] t_ms);
            mode_now   = MODE_IDLE;
            mode_since = t_ms;
        endfunction

        // Advance the mode state for one accepted beat and queue its color, if any
        function void note_item(item_t it);
            logic [31:0] el;
            logic [31:0] half;
            logic [7:0]  x;
            result_t     c;
            el = it.now_ms - mode_since;
            if (it.op == OP_SET)
            begin
                if (it.mode <= MODE_LAST)
                begin
                    mode_now   = it.mode;
                    mode_since = it.now_ms;
                end
                return;
            end
            c = '0;
            c.shown_mode = mode_now;
            case (mode_now)
                MODE_OFFLINE:
                begin
                    x = pulse_level(it.now_ms, 3, 5, 30);
                    c.red = x / 3;
                    c.green = x / 3;
                    c.blue = x / 3;
                end
                MODE_IDLE:
                begin
                    x = pulse_level(it.now_ms, 11, 55, 190);
                    c.red = x;
                    c.green = dim(x, 236);
                    c.blue = dim(x, 141);
                end
                MODE_TALK:
                begin
                    if (el >= 32'(fade_len))
                    begin
                        fall_to_idle(it.now_ms);
                        return;
                    end
                    x = 8'((32'd240 * (32'(fade_len) - el)) / 32'(fade_len));
                    c.red = x;
                    c.green = dim(x, 236);
                    c.blue = dim(x, 141);
                end
                MODE_INCOMING:
                begin
                    if (el >= 32'(incoming_len))
                    begin
                        fall_to_idle(it.now_ms);
                        return;
                    end
                    c.red = 8'd25;
                    c.green = 8'd80;
                    c.blue = pulse_level(it.now_ms, 10, 40, 220);
                end
                MODE_LIVE:
                begin
                    c.red = 8'd10;
                    c.green = pulse_level(it.now_ms, 11, 70, 230);
                    c.blue = 8'd45;
                end
                MODE_WARNING:
                begin
                    x = pulse_level(it.now_ms, 40, 100, 240);
                    c.red = x;
                    c.green = dim(x, 166);
                end
                MODE_RECORDING:
                begin
                    c.red = 8'd20;
                    c.green = 8'd65;
                    c.blue = pulse_level(it.now_ms, 10, 55, 220);
                end
                MODE_REMIND:
                begin
                    if (el >= 32'(remind_len))
                    begin
                        fall_to_idle(it.now_ms);
                        return;
                    end
                    x = pulse_level(it.now_ms, 15, 70, 210);
                    c.red = x;
                    c.green = dim(x, 210);
                end
                MODE_SOS_ARMING:
                begin
                    c.red = pulse_level(it.now_ms, 20, 90, 255);
                    c.green = 8'd5;
                    c.blue = 8'd5;
                end
                default:
                begin
                    // a zero half period blinks as if it were one
                    half = (sos_half == 16'd0) ? 32'd1 : 32'(sos_half);
                    if (((it.now_ms / half) & 32'd1) == 32'd0)
                    begin
                        c.red = 8'd255;
                        c.green = 8'd5;
                        c.blue = 8'd5;
                    end
                    else
                    begin
                        c.red = 8'd20;
                    end
                end
            endcase
            pending_colors.push_back(c);
        endfunction

        task report(string msg);
            if (errors < 40)
            begin
                $display("mismatch: %s", msg);
            end
            errors++;
        endtask

        task check_color(result_t got);
            result_t want;
            if (pending_colors.size() == 0)
            begin
                report($sformatf("color %0d/%0d/%0d mode %0d with none expected",
                                 got.red, got.green, got.blue, got.shown_mode));
                return;
            end
            want = pending_colors.pop_front();
            if (got.red !== want.red)
            begin
                report($sformatf("red %0d, expected %0d (mode %0d)",
                                 got.red, want.red, want.shown_mode));
            end
            if (got.green !== want.green)
            begin
                report($sformatf("green %0d, expected %0d (mode %0d)",
                                 got.green, want.green, want.shown_mode));
            end
            if (got.blue !== want.blue)
            begin
                report($sformatf("blue %0d, expected %0d (mode %0d)",
                                 got.blue, want.blue, want.shown_mode));
            end
            if (got.shown_mode !== want.shown_mode)
            begin
                report($sformatf("shown_mode %0d, expected %0d",
                                 got.shown_mode, want.shown_mode));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    color_checker colors;
    bit           gaps_on;
    bit           hold_results;
    logic [31:0]  sim_ms;
    int unsigned  items_sent;

    status_led_pattern_engine_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one beat, with an occasional gap ahead of it, and hold it until taken
    task automatic send_item(logic op_bit, logic [3:0] mode_val, logic [31:0] now_val);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        item_valid  = 1'b1;
        item.op     = op_bit;
        item.mode   = mode_val;
        item.now_ms = now_val;
        do @(posedge clk); while (item_stall);
        colors.note_item(item);
        if (!(op_bit == OP_SET && mode_val > MODE_LAST))
        begin
            items_sent++;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        colors.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drop valid, wait for every expected color, then let a timeout beat finish
    task automatic drain(int unsigned tail);
        @(negedge clk);
        item_valid = 1'b0;
        while (colors.pending_colors.size() != 0) @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // A set followed by a run of updates at advancing times
    task automatic play_sequence();
        logic [3:0]  m;
        int unsigned span;
        int unsigned step_max;
        int unsigned jump;
        m = 4'($urandom_range(0, 9));
        case (m)
            MODE_TALK:     span = colors.fade_len;
            MODE_INCOMING: span = colors.incoming_len;
            MODE_REMIND:   span = colors.remind_len;
            default:       span = 2000;
        endcase
        case ($urandom_range(0, 3))
            0:       step_max = 2;
            1:       step_max = 60;
            2:       step_max = span / 3 + 1;
            default: step_max = 40000;
        endcase
        jump = $urandom_range(0, 15);
        if (jump == 0)
        begin
            sim_ms = $urandom;
        end
        else if (jump == 1)
        begin
            sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        end
        sim_ms += $urandom_range(0, 500);
        send_item(OP_SET, m, sim_ms);
        repeat ($urandom_range(1, 10))
        begin
            sim_ms += $urandom_range(0, step_max);
            send_item(OP_UPDATE, 4'($urandom), sim_ms);
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_item(1'($urandom), 4'($urandom), $urandom);
            end
            else
            begin
                play_sequence();
            end
        end
    endtask

    task automatic random_regs(int unsigned top);
        write_reg(CFG_TALK_FADE, 16'($urandom_range(1, top)));
        write_reg(CFG_INCOMING, 16'($urandom_range(0, top)));
        write_reg(CFG_REMIND, 16'($urandom_range(0, top)));
        write_reg(CFG_SOS_HALF, 16'($urandom_range(1, top)));
    endtask

    // Result side: random stall bursts, plus one long hold on request
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                hold_results = 1'b0;
                result_stall = 1'b1;
                repeat (300) @(negedge clk);
                result_stall = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                result_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    // Check every color beat taken
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                colors.check_color(result);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        hold_results = 1'b0;
        sim_ms       = '0;
        items_sent   = 0;
        colors       = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: time extremes, an unknown mode, every mode near the time wrap,
        // and a fade that runs out
        send_item(OP_UPDATE, MODE_OFFLINE, 32'd0);
        send_item(OP_UPDATE, 4'hF, 32'hFFFF_FFFF);
        send_item(OP_SET, 4'hF, 32'd123);
        send_item(OP_UPDATE, MODE_OFFLINE, 32'd500);
        for (int m = 0; m <= MODE_LAST; m++)
        begin
            send_item(OP_SET, 4'(m), 32'hFFFF_FF00 + 32'(m * 50));
            send_item(OP_UPDATE, 4'(m), 32'hFFFF_FF00 + 32'(m * 50 + 30));
        end
        send_item(OP_SET, MODE_TALK, 32'd1000);
        send_item(OP_UPDATE, MODE_OFFLINE, 32'd3000);
        send_item(OP_UPDATE, MODE_OFFLINE, 32'd3001);

        // Reset settings, with one long hold on the result side
        hold_results = 1'b1;
        run_random(250);
        drain(80);

        // Shortest lengths: zero-length modes time out at once
        write_reg(CFG_TALK_FADE, 16'd1);
        write_reg(CFG_INCOMING, 16'd0);
        write_reg(CFG_REMIND, 16'd0);
        write_reg(CFG_SOS_HALF, 16'd1);
        run_random(250);
        drain(80);

        // Longest lengths
        write_reg(CFG_TALK_FADE, 16'hFFFF);
        write_reg(CFG_INCOMING, 16'hFFFF);
        write_reg(CFG_REMIND, 16'hFFFF);
        write_reg(CFG_SOS_HALF, 16'hFFFF);
        run_random(250);
        drain(80);

        // Zero SOS half period, short lengths
        random_regs(300);
        write_reg(CFG_SOS_HALF, 16'd0);
        run_random(250);
        drain(80);

        random_regs(65535);
        run_random(250);
        drain(80);

        // Last stretch runs with no idling on either side
        random_regs(8000);
        gaps_on = 1'b0;
        run_random(250);
        drain(100);

        if (colors.errors == 0 && colors.pending_colors.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
